// File: rtl/core/dlz_pkg.sv
// Shared definitions for the LZ78 DNA trie block: character and mode codes,
// configuration defaults and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package dlz_pkg;

  // Default parameter value and fixed field widths.
  localparam int MAX_TREE_DEPTH_DEF = 8;
  localparam int DEPTH_W = 4;
  localparam int MODE_W = 2;
  localparam int BYTE_W = 8;
  localparam int NODES_W = 15;
  localparam int LEAVES_W = 17;
  localparam int FULL_W = 3;
  localparam int SCORE_W = 32;

  localparam logic [DEPTH_W-1:0] TREE_DEPTH_RST = 4'd8;

  // Input word mode codes.
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCORE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // Text characters with special meaning.
  localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_HDR = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_N = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'd32;

  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic commit;  // bitmap read data is valid, finish the lookup
    logic load;    // move the finished result into the output register
    logic clear;   // write zero to the next bitmap entry
  } dlz_cmd_t;

  typedef struct packed {
    logic need_lookup;  // the offered word needs a bitmap read
    logic clear_last;   // clear sweep is at its final entry
  } dlz_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/dlz_ctrl.sv
// Controller for the LZ78 DNA trie block: bitmap clear sweep, lookup
// sequencing and the valid/stall handshakes. Depends on dlz_pkg.
`default_nettype none

module dlz_ctrl
  import dlz_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dlz_sts_t sts_i,
  output dlz_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   out_valid_q, out_valid_d;
  logic   load;
  logic   can_take;
  logic   accept;

  // A finished result waits in pend_q until the output register is free.
  assign load = pend_q && (!out_valid_q || !out_stall_i);
  assign can_take = (state_q == ST_IDLE) && (!pend_q || load);
  assign accept = can_take && in_valid_i;

  assign in_stall_o = !can_take;
  assign out_valid_o = out_valid_q;

  assign cmd_o.accept = accept;
  assign cmd_o.commit = (state_q == ST_LOOKUP);
  assign cmd_o.load = load;
  assign cmd_o.clear = (state_q == ST_CLEAR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && sts_i.need_lookup) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign pend_d = (pend_q && !load) || (accept && !sts_i.need_lookup) ||
                  (state_q == ST_LOOKUP);
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A lookup always finishes in the cycle right after its word was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (state_q == ST_IDLE))
    else $error("lookup did not finish in one cycle");

  // No word may enter while the bitmap is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("input taken during bitmap clear");

  // A word that needs no lookup leaves a pending result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !sts_i.need_lookup) |=> pend_q)
    else $error("result of a word was lost");

  // Every load into the output register shows up as a valid word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// File: rtl/core/dlz_dpath.sv
// Datapath for the LZ78 DNA trie block: FASTA line decoding, trie path,
// node bitmap memory, level counters, score counters and output register.
// Depends on dlz_pkg.
`default_nettype none

module dlz_dpath
  import dlz_pkg::*;
#(
  parameter int MAX_TREE_DEPTH = MAX_TREE_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dlz_cmd_t            cmd_i,
  output dlz_sts_t                 sts_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [BYTE_W-1:0]   text_byte_i,
  input  wire logic                cfg_we_i,
  input  wire logic [DEPTH_W-1:0]  cfg_wdata_i,
  output logic                     node_added_o,
  output logic [NODES_W-1:0]       inner_nodes_o,
  output logic [LEAVES_W-1:0]      tree_leaves_o,
  output logic [FULL_W-1:0]        complete_depth_o,
  output logic [DEPTH_W-1:0]       longest_path_o,
  output logic [SCORE_W-1:0]       scored_phrases_o,
  output logic [SCORE_W-1:0]       scored_chars_o
);

  localparam int LVL = MAX_TREE_DEPTH - 1;
  localparam int BITMAP_BITS = ((1 << (2 * MAX_TREE_DEPTH)) - 4) / 3;
  localparam int IDX_W = $clog2(BITMAP_BITS);
  localparam int PV_W = 2 * LVL;
  localparam int CNT_W = 2 * MAX_TREE_DEPTH - 1;
  localparam int CUM_W = 2 * MAX_TREE_DEPTH;
  localparam int LEAF_W = 2 * MAX_TREE_DEPTH + 1;

  // Configuration and effective depth.
  logic [DEPTH_W-1:0] tree_depth_q;
  logic [DEPTH_W-1:0] maxd;

  // Path and line state.
  logic [DEPTH_W-1:0] depth_q;
  logic [PV_W-1:0]    pv_q;
  logic [IDX_W-1:0]   base_q;
  logic               at_ls_q, at_ls_d;
  logic               in_hdr_q, in_hdr_d;
  logic               lk_build_q;
  logic               added_q;

  // Level counts; cum_q[k] holds the nodes at depths 1..k+1.
  logic [CNT_W-1:0]   cnt_q [LVL];
  logic [CUM_W-1:0]   cum_q [LVL];
  logic [LEAF_W-1:0]  leaf_q;

  logic [SCORE_W-1:0] sc_cnt_q, sc_mark_q, sc_phr_q;
  logic [SCORE_W-1:0] sc_cnt_inc, sc_phr_inc;

  // Bitmap memory and its clear sweep.
  logic               mem [BITMAP_BITS];
  logic               rd_q;
  logic [IDX_W-1:0]   clr_q;
  logic [IDX_W-1:0]   rd_addr, wr_addr, mem_wa;
  logic               mem_we, mem_wd;

  // Word decode.
  logic               is_char, path_rst, clear_sc;
  logic [BYTE_W-1:0]  up;
  logic               is_n, is_nuc;
  logic [1:0]         code;
  logic [PV_W-1:0]    pv_or;
  logic               in_range;
  logic               node_add;
  logic [DEPTH_W-1:0] lvl_idx;

  // Summaries.
  logic [CUM_W-1:0]   nodes_sum;
  logic [DEPTH_W-1:0] fd, lp;
  logic               fd_done, lp_done;

  always_comb begin
    if (tree_depth_q == '0) begin
      maxd = DEPTH_W'(1);
    end else if (tree_depth_q > DEPTH_W'(MAX_TREE_DEPTH)) begin
      maxd = DEPTH_W'(MAX_TREE_DEPTH);
    end else begin
      maxd = tree_depth_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_depth_q <= TREE_DEPTH_RST;
    end else if (cfg_we_i) begin
      tree_depth_q <= cfg_wdata_i;
    end
  end

  // FASTA line handling: headers and empty lines restart the path, the
  // newline that ends a sequence line does not.
  always_comb begin
    is_char = 1'b0;
    path_rst = 1'b0;
    clear_sc = 1'b0;
    at_ls_d = at_ls_q;
    in_hdr_d = in_hdr_q;
    case (mode_i)
      MODE_BEGIN: begin
        clear_sc = 1'b1;
        path_rst = 1'b1;
        at_ls_d = 1'b1;
        in_hdr_d = 1'b0;
      end
      MODE_BUILD, MODE_SCORE: begin
        if (in_hdr_q) begin
          if (text_byte_i == CH_NL) begin
            in_hdr_d = 1'b0;
            at_ls_d = 1'b1;
          end
        end else if (at_ls_q) begin
          if (text_byte_i == CH_HDR) begin
            path_rst = 1'b1;
            in_hdr_d = 1'b1;
            at_ls_d = 1'b0;
          end else if (text_byte_i == CH_NL) begin
            path_rst = 1'b1;
          end else begin
            at_ls_d = 1'b0;
            is_char = 1'b1;
          end
        end else if (text_byte_i == CH_NL) begin
          at_ls_d = 1'b1;
        end else begin
          is_char = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign up = (text_byte_i >= CH_LOWER_A) ? text_byte_i - CASE_OFS : text_byte_i;
  assign is_n = is_char && (up == CH_N);
  assign is_nuc = is_char && (up != CH_N);
  assign code = text_byte_i[2:1];
  assign pv_or = pv_q | PV_W'(code);
  assign in_range = depth_q < maxd;

  assign sts_o.need_lookup = is_nuc && in_range;
  assign sts_o.clear_last = (clr_q == IDX_W'(BITMAP_BITS - 1));

  assign sc_cnt_inc = (sc_cnt_q == '1) ? sc_cnt_q : sc_cnt_q + SCORE_W'(1);
  assign sc_phr_inc = (sc_phr_q == '1) ? sc_phr_q : sc_phr_q + SCORE_W'(1);

  assign rd_addr = base_q + IDX_W'(pv_or);
  assign wr_addr = base_q + IDX_W'(pv_q);
  assign node_add = cmd_i.commit && lk_build_q && !rd_q;
  assign lvl_idx = depth_q - DEPTH_W'(1);

  assign mem_we = cmd_i.clear || node_add;
  assign mem_wa = cmd_i.clear ? clr_q : wr_addr;
  assign mem_wd = !cmd_i.clear;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && !sts_o.clear_last) begin
      clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Path, line and score state. A lookup word stores path|code at accept
  // and decides on the bitmap bit in the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_W'(1);
      pv_q <= '0;
      base_q <= '0;
      at_ls_q <= 1'b1;
      in_hdr_q <= 1'b0;
      added_q <= 1'b0;
      sc_cnt_q <= '0;
      sc_mark_q <= '0;
      sc_phr_q <= '0;
    end else if (cmd_i.accept) begin
      at_ls_q <= at_ls_d;
      in_hdr_q <= in_hdr_d;
      added_q <= 1'b0;
      if (clear_sc) begin
        sc_cnt_q <= '0;
        sc_mark_q <= '0;
        sc_phr_q <= '0;
      end
      if (path_rst || is_n) begin
        depth_q <= DEPTH_W'(1);
        pv_q <= '0;
        base_q <= '0;
      end else if (is_nuc) begin
        if (mode_i == MODE_SCORE) begin
          sc_cnt_q <= sc_cnt_inc;
        end
        if (in_range) begin
          pv_q <= pv_or;
        end else begin
          if (mode_i == MODE_SCORE) begin
            sc_phr_q <= sc_phr_inc;
            sc_mark_q <= sc_cnt_inc;
          end
          depth_q <= DEPTH_W'(1);
          pv_q <= '0;
          base_q <= '0;
        end
      end
    end else if (cmd_i.commit) begin
      if (lk_build_q) begin
        if (!rd_q) begin
          added_q <= 1'b1;
          depth_q <= DEPTH_W'(1);
          pv_q <= '0;
          base_q <= '0;
        end else if (depth_q == maxd - DEPTH_W'(1)) begin
          depth_q <= DEPTH_W'(1);
          pv_q <= '0;
          base_q <= '0;
        end else begin
          depth_q <= depth_q + DEPTH_W'(1);
          pv_q <= pv_q << 2;
          base_q <= (base_q << 2) + IDX_W'(4);
        end
      end else begin
        if (rd_q) begin
          depth_q <= depth_q + DEPTH_W'(1);
          pv_q <= pv_q << 2;
          base_q <= (base_q << 2) + IDX_W'(4);
        end else begin
          sc_phr_q <= sc_phr_inc;
          sc_mark_q <= sc_cnt_q;
          depth_q <= DEPTH_W'(1);
          pv_q <= '0;
          base_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lk_build_q <= (mode_i == MODE_BUILD);
    end
  end

  // Level counters. The running sums let the node total be picked by depth
  // instead of added up every word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LVL; k++) begin
        cnt_q[k] <= '0;
        cum_q[k] <= '0;
      end
      leaf_q <= LEAF_W'(4);
    end else if (node_add) begin
      for (int k = 0; k < LVL; k++) begin
        if (lvl_idx == DEPTH_W'(k)) begin
          cnt_q[k] <= cnt_q[k] + CNT_W'(1);
        end
        if (lvl_idx <= DEPTH_W'(k)) begin
          cum_q[k] <= cum_q[k] + CUM_W'(1);
        end
      end
      leaf_q <= leaf_q + LEAF_W'(3);
    end
  end

  always_comb begin
    nodes_sum = '0;
    for (int k = 0; k < LVL; k++) begin
      if (DEPTH_W'(k + 2) == maxd) begin
        nodes_sum = cum_q[k];
      end
    end
  end

  // Full depth stops at the first incomplete level; longest path stops at
  // the first empty level. Full depth stays below the effective depth; longest path reaches it at most.
  always_comb begin
    fd = '0;
    lp = DEPTH_W'(1);
    fd_done = 1'b0;
    lp_done = 1'b0;
    for (int k = 0; k < LVL; k++) begin
      if (!fd_done && (DEPTH_W'(k + 1) < maxd) &&
          (cnt_q[k] == (CNT_W'(1) << (2 * k + 2)))) begin
        fd = DEPTH_W'(k + 1);
      end else begin
        fd_done = 1'b1;
      end
      if (!lp_done && (DEPTH_W'(k + 1) < maxd) && (cnt_q[k] != '0)) begin
        lp = DEPTH_W'(k + 2);
      end else begin
        lp_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      node_added_o <= added_q;
      inner_nodes_o <= NODES_W'(nodes_sum + CUM_W'(1));
      tree_leaves_o <= LEAVES_W'(leaf_q);
      complete_depth_o <= FULL_W'(fd);
      longest_path_o <= lp;
      scored_phrases_o <= sc_phr_q;
      scored_chars_o <= sc_mark_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dna_lz78_trie_bitmap_top.sv
// LZ78 DNA trie block: one FASTA byte per word, one result word per byte.
// Each result waits in a pending flag, then loads into the output register.
// A byte that reads the node bitmap stalls the next byte until its synchronous
// read has decided the next path step; a held output register also stalls input.
// Reset: all (4^MAX_TREE_DEPTH-4)/3 node bitmap entries (21844 by default) are
// swept to zero, one entry per cycle; input stalls meanwhile.
`default_nettype none

module dna_lz78_trie_bitmap_top
  import dlz_pkg::*;
#(
  parameter int MAX_TREE_DEPTH = MAX_TREE_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [DEPTH_W-1:0]  cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [BYTE_W-1:0]   text_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     node_added_o,
  output logic [NODES_W-1:0]       inner_nodes_o,
  output logic [LEAVES_W-1:0]      tree_leaves_o,
  output logic [FULL_W-1:0]        complete_depth_o,
  output logic [DEPTH_W-1:0]       longest_path_o,
  output logic [SCORE_W-1:0]       scored_phrases_o,
  output logic [SCORE_W-1:0]       scored_chars_o
);

  dlz_cmd_t cmd;
  dlz_sts_t sts;

  dlz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlz_dpath #(
    .MAX_TREE_DEPTH(MAX_TREE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .text_byte_i     (text_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .node_added_o    (node_added_o),
    .inner_nodes_o   (inner_nodes_o),
    .tree_leaves_o   (tree_leaves_o),
    .complete_depth_o(complete_depth_o),
    .longest_path_o  (longest_path_o),
    .scored_phrases_o(scored_phrases_o),
    .scored_chars_o  (scored_chars_o)
  );

endmodule

`default_nettype wire

// File: tb/dlz_trie_checker.sv
`timescale 1ns / 100ps
// Checker for the LZ78 DNA trie block: follows the depth register and both
// word channels, predicts each result word and compares it field by field.
// Depends on dlz_pkg.

module dlz_trie_checker
  import dlz_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [DEPTH_W-1:0]  cfg_wdata_i,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [BYTE_W-1:0]   text_byte_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire logic                node_added_i,
  input  wire logic [NODES_W-1:0]  inner_nodes_i,
  input  wire logic [LEAVES_W-1:0] tree_leaves_i,
  input  wire logic [FULL_W-1:0]   complete_depth_i,
  input  wire logic [DEPTH_W-1:0]  longest_path_i,
  input  wire logic [SCORE_W-1:0]  scored_phrases_i,
  input  wire logic [SCORE_W-1:0]  scored_chars_i,
  output int                       mismatch_count_o,
  output int                       pending_o
);

  localparam int MAXD = MAX_TREE_DEPTH_DEF;
  localparam int NODE_BITS = ((1 << (2 * MAXD)) - 4) / 3;

  typedef struct packed {
    logic                node_added;
    logic [NODES_W-1:0]  inner_nodes;
    logic [LEAVES_W-1:0] tree_leaves;
    logic [FULL_W-1:0]   complete_depth;
    logic [DEPTH_W-1:0]  longest_path;
    logic [SCORE_W-1:0]  scored_phrases;
    logic [SCORE_W-1:0]  scored_chars;
  } trie_result_t;

  bit                   node_map [NODE_BITS];
  logic [NODES_W-1:0]   level_nodes [1:MAXD-1];
  logic [DEPTH_W-1:0]   walk_depth;
  logic [2*MAXD-1:0]    walk_value;
  logic [LEAVES_W-1:0]  leaf_tally;
  logic [SCORE_W-1:0]   char_count;
  logic [SCORE_W-1:0]   char_mark;
  logic [SCORE_W-1:0]   phrase_count;
  bit                   line_start;
  bit                   header_line;
  logic [DEPTH_W-1:0]   depth_setting;

  trie_result_t         expected_words [$];
  trie_result_t         fresh_word;
  trie_result_t         oldest_word;
  int                   mismatches = 0;
  int                   pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o = pending;

  // First bitmap index of the nodes at depth d+1.
  function automatic int unsigned level_base(input int unsigned d);
    return ((1 << (2 * d + 2)) - 4) / 3;
  endfunction

  function automatic bit node_present(input int unsigned idx);
    return (idx < NODE_BITS) ? node_map[idx] : 1'b0;
  endfunction

  task automatic restart_walk();
    walk_depth = DEPTH_W'(1);
    walk_value = '0;
  endtask

  task automatic clear_trie_model();
    node_map = '{default: 1'b0};
    level_nodes = '{default: '0};
    restart_walk();
    leaf_tally = LEAVES_W'(4);
    char_count = '0;
    char_mark = '0;
    phrase_count = '0;
    line_start = 1'b1;
    header_line = 1'b0;
    depth_setting = TREE_DEPTH_RST;
  endtask

  task automatic grow_trie(input logic [1:0] code, input int unsigned maxd,
                           output logic added);
    int unsigned idx;
    added = 1'b0;
    walk_value = walk_value | code;
    if (walk_depth > maxd - 1) begin
      restart_walk();
    end else begin
      idx = level_base(walk_depth - 1) + walk_value;
      if (!node_present(idx)) begin
        node_map[idx] = 1'b1;
        level_nodes[walk_depth] = level_nodes[walk_depth] + NODES_W'(1);
        leaf_tally = leaf_tally + LEAVES_W'(3);
        restart_walk();
        added = 1'b1;
      end else if (walk_depth == maxd - 1) begin
        restart_walk();
      end else begin
        walk_value = walk_value << 2;
        walk_depth = walk_depth + DEPTH_W'(1);
      end
    end
  endtask

  task automatic score_against_trie(input logic [1:0] code, input int unsigned maxd);
    if (char_count != '1) char_count = char_count + SCORE_W'(1);
    walk_value = walk_value | code;
    if (walk_depth < maxd && node_present(level_base(walk_depth - 1) + walk_value)) begin
      walk_value = walk_value << 2;
      walk_depth = walk_depth + DEPTH_W'(1);
    end else begin
      if (phrase_count != '1) phrase_count = phrase_count + SCORE_W'(1);
      char_mark = char_count;
      restart_walk();
    end
  endtask

  task automatic predict_trie_word(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
                                   output trie_result_t r);
    int unsigned maxd;
    int unsigned total;
    int unsigned fd;
    int unsigned lp;
    int unsigned d;
    bit is_char;
    logic [BYTE_W-1:0] folded;
    logic added;
    if (depth_setting == 0) maxd = 1;
    else if (depth_setting > MAXD) maxd = MAXD;
    else maxd = depth_setting;
    added = 1'b0;
    if (m == MODE_BEGIN) begin
      char_count = '0;
      char_mark = '0;
      phrase_count = '0;
      restart_walk();
      line_start = 1'b1;
      header_line = 1'b0;
    end else if (m != MODE_NONE) begin
      is_char = 1'b1;
      if (header_line) begin
        if (b == CH_NL) begin
          header_line = 1'b0;
          line_start = 1'b1;
        end
        is_char = 1'b0;
      end else if (line_start) begin
        if (b == CH_HDR) begin
          restart_walk();
          header_line = 1'b1;
          line_start = 1'b0;
          is_char = 1'b0;
        end else if (b == CH_NL) begin
          restart_walk();
          is_char = 1'b0;
        end else begin
          line_start = 1'b0;
        end
      end else if (b == CH_NL) begin
        line_start = 1'b1;
        is_char = 1'b0;
      end
      if (is_char) begin
        folded = (b >= CH_LOWER_A) ? b - CASE_OFS : b;
        if (folded == CH_N) restart_walk();
        else if (m == MODE_BUILD) grow_trie(b[2:1], maxd, added);
        else score_against_trie(b[2:1], maxd);
      end
    end
    // Node statistics only look at depths below the current setting.
    total = 1;
    for (d = 1; d < maxd; d++) total += level_nodes[d];
    fd = 0;
    while (fd + 1 < maxd && level_nodes[fd + 1] == (1 << (2 * fd + 2))) fd++;
    lp = 1;
    while (lp < maxd && level_nodes[lp] != 0) lp++;
    r.node_added = added;
    r.inner_nodes = NODES_W'(total);
    r.tree_leaves = leaf_tally;
    r.complete_depth = FULL_W'(fd);
    r.longest_path = DEPTH_W'(lp);
    r.scored_phrases = phrase_count;
    r.scored_chars = char_mark;
  endtask

  task automatic check_field(input string name, input logic [SCORE_W-1:0] want,
                             input logic [SCORE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_trie_model();
      expected_words.delete();
      pending = 0;
    end else begin
      if (cfg_we_i) depth_setting = cfg_wdata_i;
      // Compare before predicting so a new word never meets its own result.
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word arrived with nothing expected", $time);
        end else begin
          oldest_word = expected_words.pop_front();
          check_field("node_added", oldest_word.node_added, node_added_i);
          check_field("inner_nodes", oldest_word.inner_nodes, inner_nodes_i);
          check_field("tree_leaves", oldest_word.tree_leaves, tree_leaves_i);
          check_field("complete_depth", oldest_word.complete_depth, complete_depth_i);
          check_field("longest_path", oldest_word.longest_path, longest_path_i);
          check_field("scored_phrases", oldest_word.scored_phrases, scored_phrases_i);
          check_field("scored_chars", oldest_word.scored_chars, scored_chars_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_trie_word(mode_i, text_byte_i, fresh_word);
        expected_words.push_back(fresh_word);
      end
      pending = expected_words.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for dna_lz78_trie_bitmap_top: feeds FASTA text under a
// series of depth settings and gives the verdict.
// Depends on dlz_pkg, dlz_trie_checker and the block itself.

module testbench;
  import dlz_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [DEPTH_W-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i = MODE_BUILD;
  logic [BYTE_W-1:0]   text_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                node_added_o;
  logic [NODES_W-1:0]  inner_nodes_o;
  logic [LEAVES_W-1:0] tree_leaves_o;
  logic [FULL_W-1:0]   complete_depth_o;
  logic [DEPTH_W-1:0]  longest_path_o;
  logic [SCORE_W-1:0]  scored_phrases_o;
  logic [SCORE_W-1:0]  scored_chars_o;

  int                  mismatches;
  int                  pending;
  int                  words_sent = 0;
  bit                  no_gaps = 1'b0;
  logic [DEPTH_W-1:0]  depth_plan [0:8] = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd9, 4'd4,
                                            4'd8, 4'd5};

  dna_lz78_trie_bitmap_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .text_byte_i     (text_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .node_added_o    (node_added_o),
    .inner_nodes_o   (inner_nodes_o),
    .tree_leaves_o   (tree_leaves_o),
    .complete_depth_o(complete_depth_o),
    .longest_path_o  (longest_path_o),
    .scored_phrases_o(scored_phrases_o),
    .scored_chars_o  (scored_chars_o)
  );

  dlz_trie_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .mode_i          (mode_i),
    .text_byte_i     (text_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .node_added_i    (node_added_o),
    .inner_nodes_i   (inner_nodes_o),
    .tree_leaves_i   (tree_leaves_o),
    .complete_depth_i(complete_depth_o),
    .longest_path_i  (longest_path_o),
    .scored_phrases_i(scored_phrases_o),
    .scored_chars_i  (scored_chars_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 24);
  end

  // Offers one word and returns at the edge that accepts it, with valid still high.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b);
    while (!no_gaps && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    text_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_text(input logic [MODE_W-1:0] m, input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(m, s[i]);
  endtask

  // Mostly ACGT in both cases, with the odd N and carriage return.
  function automatic logic [BYTE_W-1:0] pick_base();
    int unsigned r;
    string letters;
    letters = "ACGTacgt";
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? "N" : "n";
    if (r < 5) return 8'h0D;
    return letters[$urandom_range(0, 7)];
  endfunction

  task automatic random_text(input logic [MODE_W-1:0] start_mode, input int n_words);
    int sent;
    int len;
    int unsigned pick;
    logic [MODE_W-1:0] m;
    sent = 0;
    m = start_mode;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        send_word(m, CH_HDR);
        len = $urandom_range(0, 5);
        repeat (len) send_word(m, BYTE_W'($urandom_range(32, 126)));
        send_word(m, CH_NL);
        sent++;
      end else if (pick < 11) begin
        send_word(m, CH_NL);
        sent++;
      end else if (pick < 20) begin
        // Noise: any byte under any mode, which also breaks up line structure.
        send_word(MODE_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        len = $urandom_range(1, 24);
        repeat (len) begin
          if ($urandom_range(0, 99) < 2) m = (m == MODE_BUILD) ? MODE_SCORE : MODE_BUILD;
          send_word(m, pick_base());
        end
        send_word(m, CH_NL);
        sent += len + 1;
      end
    end
  endtask

  task automatic set_depth(input logic [DEPTH_W-1:0] d);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed text at the reset depth: header, empty line, both cases,
    // odd bytes taken as nucleotides, N in both cases, unused and begin modes.
    send_text(MODE_BUILD, ">x\n\nACgt");
    send_word(MODE_BUILD, 8'h00);
    send_word(MODE_BUILD, 8'hFF);
    send_word(MODE_BUILD, 8'h80);
    send_word(MODE_BUILD, 8'h0D);
    send_word(MODE_BUILD, "5");
    send_word(MODE_BUILD, CH_HDR);
    send_text(MODE_BUILD, "Nn\n\n");
    send_word(MODE_NONE, 8'hFF);
    send_word(MODE_BEGIN, 8'hA5);
    send_text(MODE_SCORE, "Acg\n");

    for (int p = 0; p < 9; p++) begin
      no_gaps = (p == 4);
      set_depth(depth_plan[p]);
      random_text(MODE_BUILD, 70);
      send_word(MODE_BEGIN, BYTE_W'($urandom_range(0, 255)));
      random_text(MODE_SCORE, 48);
    end
    no_gaps = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d text words under nine depth settings, build and score mixed.",
             words_sent);
    $display("Trie ended with %0d inner nodes and %0d leaves.", inner_nodes_o,
             tree_leaves_o);
    if (mismatches == 0) begin
      $display("** dna_lz78_trie_bitmap_top: PASSED **");
    end else begin
      $display("** dna_lz78_trie_bitmap_top: FAILED **");
    end
    $finish;
  end

  // The timeout must also cover the bitmap sweep after reset.
  initial begin
    #5000000;
    $display("Run timed out with %0d result words outstanding.", pending);
    $display("** dna_lz78_trie_bitmap_top: FAILED **");
    $finish;
  end

endmodule
